>>> design/plx_pkg.sv
// Package for the pixel to laser pose transform unit.
// Holds the shared payload types, register indexes and the saturation helper.
// No dependencies.
package plx_pkg;

   localparam int PIPE_DEPTH = 23;

   localparam logic [39:0] IMAGE_ROTATION_RESET   = 40'd262144;
   localparam logic [63:0] MACHINE_ROTATION_RESET = 64'd262144;

   typedef enum logic [2:0] {
      CSR_OPTICAL_CENTER,
      CSR_DISTORTION_COEFFS,
      CSR_PIXEL_PITCH,
      CSR_IMAGE_ROTATION,
      CSR_IMAGE_TRANSLATION,
      CSR_MACHINE_ROTATION,
      CSR_MACHINE_TRANSLATION,
      CSR_LASER_OFFSET
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_angle;
   } origin_type;

   typedef struct packed {
      logic signed [24:0] dx;
      logic signed [24:0] dy;
      logic signed [45:0] scale;
      origin_type         origin;
   } dist_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic               clip;
      origin_type         origin;
   } point_type;

   typedef struct packed {
      logic signed [31:0] laser_x;
      logic signed [31:0] laser_y;
      logic signed [31:0] laser_angle;
      logic               clipped;
   } result_type;

   // Returns {clip, value} for a value saturated to 32-bit signed.
   function automatic logic [32:0] sat32(input logic signed [63:0] v);
      logic [32:0] r;
      priority if (v > 64'sd2147483647) begin
         r = {1'b1, 32'h7fffffff};
      end else if (v < -64'sd2147483648) begin
         r = {1'b1, 32'h80000000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

>>> design/plx_if.sv
// Channel interfaces of the pixel to laser pose transform unit.
// Request carries a pixel and an origin pose, response carries the laser pose.
// No dependencies.
interface plx_req_if;
   logic               valid;
   logic               ready;
   logic [23:0]        pixel_x;
   logic [23:0]        pixel_y;
   logic signed [31:0] origin_x;
   logic signed [31:0] origin_y;
   logic signed [31:0] origin_angle;
   modport source(output valid, pixel_x, pixel_y, origin_x, origin_y, origin_angle,
                  input ready);
   modport sink(input valid, pixel_x, pixel_y, origin_x, origin_y, origin_angle,
                output ready);
endinterface

interface plx_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] laser_x;
   logic signed [31:0] laser_y;
   logic signed [31:0] laser_angle;
   logic               clipped;
   modport source(output valid, laser_x, laser_y, laser_angle, clipped, input ready);
   modport sink(input valid, laser_x, laser_y, laser_angle, clipped, output ready);
endinterface

>>> design/plx_distort.sv
// Radial distortion stage chain: offset from the optical center, r squared and
// the scale factor 1 + k1*r^2 + k2*r^4 in Q.32, over ten register stages.
// Depends on plx_pkg.
module plx_distort import plx_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [23:0]        pixel_x,
   input  logic [23:0]        pixel_y,
   input  origin_type         origin_in,
   input  logic [23:0]        center_x,
   input  logic [23:0]        center_y,
   input  logic signed [31:0] k1,
   input  logic signed [31:0] k2,
   output logic               out_valid,
   input  logic               out_ready,
   output dist_type           out_data
);

   localparam int Stages = 10;

   logic [Stages-1:0] vld_ff, vld_in;
   logic [Stages:0]   rdy;
   origin_type        org_ff [Stages];
   logic [49:0]       dxy_ff [Stages];

   logic signed [24:0] dx_in, dy_in;
   logic [48:0] sqx_in, sqy_in, sqx_ff, sqy_ff;
   logic [24:0] adx, ady, ndx, ndy;
   logic [49:0] r2_in, r2_2_ff, r2_3_ff, r2_4_ff, r2_5_ff;
   logic [31:0] ak2, nk2;
   logic [56:0] pkl_in, pkh_in, pkl_ff, pkh_ff;
   logic [81:0] p5;
   logic [33:0] q2_in, q2_ff;
   logic [41:0] q2e, inner_in, inner_ff, inner_neg;
   logic [40:0] ain;
   logic [45:0] p00_in, p01_in, p00_ff, p01_ff;
   logic [44:0] p10_in, p11_in, p10_ff, p11_ff;
   logic        neg6_ff, neg7_ff, neg8_ff;
   logic [70:0] a_in, a_ff;
   logic [69:0] b_in, b_ff;
   logic [91:0] s9;
   logic [43:0] q_in, q_ff;
   logic [45:0] qe, scale_in, scale_ff;

   always_comb begin
      rdy[Stages] = out_ready;
      for (int k = Stages - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in = (rdy[Stages-1:0] & {vld_ff[Stages-2:0], in_valid})
             | (~rdy[Stages-1:0] & vld_ff);
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[Stages-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      dx_in = $signed({1'b0, pixel_x}) - $signed({1'b0, center_x});
      dy_in = $signed({1'b0, pixel_y}) - $signed({1'b0, center_y});
      ndx = -dxy_ff[0][49:25];
      ndy = -dxy_ff[0][24:0];
      adx = dxy_ff[0][49] ? ndx : dxy_ff[0][49:25];
      ady = dxy_ff[0][24] ? ndy : dxy_ff[0][24:0];
      sqx_in = 49'(50'(adx) * 50'(adx));
      sqy_in = 49'(50'(ady) * 50'(ady));
      r2_in = 50'(sqx_ff) + 50'(sqy_ff);
      nk2 = -k2;
      ak2 = k2[31] ? nk2 : k2;
      pkl_in = 57'(ak2) * 57'(r2_2_ff[24:0]);
      pkh_in = 57'(ak2) * 57'(r2_2_ff[49:25]);
      p5 = 82'(pkl_ff) + (82'(pkh_ff) << 25) + (82'(1) << 47);
      q2_in = p5[81:48];
      q2e = {8'd0, q2_ff};
      inner_in = {{2{k1[31]}}, k1, 8'd0} + (k2[31] ? -q2e : q2e);
      inner_neg = -inner_ff;
      ain = inner_ff[41] ? inner_neg[40:0] : inner_ff[40:0];
      p00_in = 46'(ain[20:0]) * 46'(r2_5_ff[24:0]);
      p01_in = 46'(ain[20:0]) * 46'(r2_5_ff[49:25]);
      p10_in = 45'(ain[40:21]) * 45'(r2_5_ff[24:0]);
      p11_in = 45'(ain[40:21]) * 45'(r2_5_ff[49:25]);
      a_in = 71'(p00_ff) + (71'(p01_ff) << 25);
      b_in = 70'(p10_ff) + (70'(p11_ff) << 25);
      s9 = 92'(a_ff) + (92'(b_ff) << 21) + (92'(1) << 47);
      q_in = s9[91:48];
      qe = {2'b00, q_ff};
      scale_in = (46'(1) << 32) + (neg8_ff ? -qe : qe);
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         org_ff[0] <= origin_in;
         dxy_ff[0] <= {dx_in, dy_in};
      end
      for (int k = 1; k < Stages; k++) begin
         if (rdy[k]) begin
            org_ff[k] <= org_ff[k-1];
            dxy_ff[k] <= dxy_ff[k-1];
         end
      end
      if (rdy[1]) begin
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
      end
      if (rdy[2]) begin
         r2_2_ff <= r2_in;
      end
      if (rdy[3]) begin
         pkl_ff  <= pkl_in;
         pkh_ff  <= pkh_in;
         r2_3_ff <= r2_2_ff;
      end
      if (rdy[4]) begin
         q2_ff   <= q2_in;
         r2_4_ff <= r2_3_ff;
      end
      if (rdy[5]) begin
         inner_ff <= inner_in;
         r2_5_ff  <= r2_4_ff;
      end
      if (rdy[6]) begin
         p00_ff  <= p00_in;
         p01_ff  <= p01_in;
         p10_ff  <= p10_in;
         p11_ff  <= p11_in;
         neg6_ff <= inner_ff[41];
      end
      if (rdy[7]) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         neg7_ff <= neg6_ff;
      end
      if (rdy[8]) begin
         q_ff    <= q_in;
         neg8_ff <= neg7_ff;
      end
      if (rdy[9]) begin
         scale_ff <= scale_in;
      end
   end

   always_comb begin
      out_data.dx     = dxy_ff[Stages-1][49:25];
      out_data.dy     = dxy_ff[Stages-1][24:0];
      out_data.scale  = scale_ff;
      out_data.origin = org_ff[Stages-1];
   end

endmodule

>>> design/plx_scale.sv
// Applies the distortion scale to the pixel offset and converts it to
// millimeters per axis with saturation, over five register stages.
// Depends on plx_pkg.
module plx_scale import plx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  dist_type    in_data,
   input  logic [31:0] pitch_x,
   input  logic [31:0] pitch_y,
   output logic        out_valid,
   input  logic        out_ready,
   output point_type   out_data
);

   localparam int Stages = 5;

   logic [Stages-1:0] vld_ff, vld_in;
   logic [Stages:0]   rdy;
   origin_type        org_ff [Stages];

   logic [24:0] d [2];
   logic [24:0] dn [2];
   logic [24:0] ad [2];
   logic [31:0] pitch [2];
   logic [45:0] sneg;
   logic [44:0] as_mag;
   logic [47:0] pl_in [2];
   logic [47:0] pl_ff [2];
   logic [46:0] ph_in [2];
   logic [46:0] ph_ff [2];
   logic        neg_in [2];
   logic        neg1_ff [2];
   logic        neg2_ff [2];
   logic        neg3_ff [2];
   logic        neg4_ff [2];
   logic [69:0] s2 [2];
   logic [37:0] u_in [2];
   logic [37:0] u_ff [2];
   logic [50:0] ml_in [2];
   logic [50:0] ml_ff [2];
   logic [50:0] mh_in [2];
   logic [50:0] mh_ff [2];
   logic [71:0] s4 [2];
   logic [50:0] m_in [2];
   logic [50:0] m_ff [2];
   logic [51:0] mv [2];
   logic [51:0] v [2];
   logic [32:0] sat [2];
   logic signed [31:0] xy_ff [2];
   logic        clip_ff;

   always_comb begin
      rdy[Stages] = out_ready;
      for (int k = Stages - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in = (rdy[Stages-1:0] & {vld_ff[Stages-2:0], in_valid})
             | (~rdy[Stages-1:0] & vld_ff);
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[Stages-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      d[0] = in_data.dx;
      d[1] = in_data.dy;
      pitch[0] = pitch_x;
      pitch[1] = pitch_y;
      sneg = -in_data.scale;
      as_mag = in_data.scale[45] ? sneg[44:0] : in_data.scale[44:0];
      for (int l = 0; l < 2; l++) begin
         dn[l] = -d[l];
         ad[l] = d[l][24] ? dn[l] : d[l];
         pl_in[l] = 48'(ad[l]) * 48'(as_mag[22:0]);
         ph_in[l] = 47'(ad[l]) * 47'(as_mag[44:23]);
         neg_in[l] = d[l][24] ^ in_data.scale[45];
         s2[l] = 70'(pl_ff[l]) + (70'(ph_ff[l]) << 23) + (70'(1) << 31);
         u_in[l] = s2[l][69:32];
         ml_in[l] = 51'(u_ff[l][18:0]) * 51'(pitch[l]);
         mh_in[l] = 51'(u_ff[l][37:19]) * 51'(pitch[l]);
         s4[l] = 72'(ml_ff[l]) + (72'(mh_ff[l]) << 19) + (72'(1) << 19);
         m_in[l] = s4[l][70:20];
         mv[l] = {1'b0, m_ff[l]};
         v[l] = neg4_ff[l] ? -mv[l] : mv[l];
         sat[l] = sat32(64'($signed(v[l])));
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         org_ff[0] <= in_data.origin;
      end
      for (int k = 1; k < Stages; k++) begin
         if (rdy[k]) begin
            org_ff[k] <= org_ff[k-1];
         end
      end
      for (int l = 0; l < 2; l++) begin
         if (rdy[0]) begin
            pl_ff[l]   <= pl_in[l];
            ph_ff[l]   <= ph_in[l];
            neg1_ff[l] <= neg_in[l];
         end
         if (rdy[1]) begin
            u_ff[l]    <= u_in[l];
            neg2_ff[l] <= neg1_ff[l];
         end
         if (rdy[2]) begin
            ml_ff[l]   <= ml_in[l];
            mh_ff[l]   <= mh_in[l];
            neg3_ff[l] <= neg2_ff[l];
         end
         if (rdy[3]) begin
            m_ff[l]    <= m_in[l];
            neg4_ff[l] <= neg3_ff[l];
         end
         if (rdy[4]) begin
            xy_ff[l] <= sat[l][31:0];
         end
      end
      if (rdy[4]) begin
         clip_ff <= sat[0][32] | sat[1][32];
      end
   end

   always_comb begin
      out_data.x      = xy_ff[0];
      out_data.y      = xy_ff[1];
      out_data.clip   = clip_ff;
      out_data.origin = org_ff[Stages-1];
   end

endmodule

>>> design/plx_rigid.sv
// One rigid 2D transform: rotation by a cosine and sine in Q2.18, rounding,
// then translation with saturation, over three register stages.
// Depends on plx_pkg.
module plx_rigid import plx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  point_type   in_data,
   input  logic [39:0] rotation,
   input  logic [63:0] translation,
   output logic        out_valid,
   input  logic        out_ready,
   output point_type   out_data
);

   localparam int Stages = 3;

   logic [Stages-1:0] vld_ff, vld_in;
   logic [Stages:0]   rdy;
   origin_type        org_ff [Stages];
   logic              clip_ff [Stages];

   logic signed [19:0] cosv, sinv;
   logic signed [31:0] px, py;
   logic signed [51:0] xc_in, ys_in, xs_in, yc_in, xc_ff, ys_ff, xs_ff, yc_ff;
   logic signed [52:0] vx, vy;
   logic signed [34:0] rx_in, ry_in, rx_ff, ry_ff;
   logic signed [31:0] tx, ty;
   logic signed [35:0] sx, sy;
   logic [32:0]        satx, saty;
   logic signed [31:0] x_ff, y_ff;

   always_comb begin
      rdy[Stages] = out_ready;
      for (int k = Stages - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in = (rdy[Stages-1:0] & {vld_ff[Stages-2:0], in_valid})
             | (~rdy[Stages-1:0] & vld_ff);
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[Stages-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      cosv  = rotation[19:0];
      sinv  = rotation[39:20];
      px    = in_data.x;
      py    = in_data.y;
      xc_in = px * cosv;
      ys_in = py * sinv;
      xs_in = px * sinv;
      yc_in = py * cosv;
      vx    = 53'(xc_ff) - 53'(ys_ff) + 53'sd131072;
      vy    = 53'(xs_ff) + 53'(yc_ff) + 53'sd131072;
      rx_in = vx[52:18];
      ry_in = vy[52:18];
      tx    = translation[31:0];
      ty    = translation[63:32];
      sx    = 36'(rx_ff) + 36'(tx);
      sy    = 36'(ry_ff) + 36'(ty);
      satx  = sat32(64'(sx));
      saty  = sat32(64'(sy));
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         org_ff[0]  <= in_data.origin;
         clip_ff[0] <= in_data.clip;
         xc_ff <= xc_in;
         ys_ff <= ys_in;
         xs_ff <= xs_in;
         yc_ff <= yc_in;
      end
      if (rdy[1]) begin
         org_ff[1]  <= org_ff[0];
         clip_ff[1] <= clip_ff[0];
         rx_ff <= rx_in;
         ry_ff <= ry_in;
      end
      if (rdy[2]) begin
         org_ff[2]  <= org_ff[1];
         clip_ff[2] <= clip_ff[1] | satx[32] | saty[32];
         x_ff <= satx[31:0];
         y_ff <= saty[31:0];
      end
   end

   always_comb begin
      out_data.x      = x_ff;
      out_data.y      = y_ff;
      out_data.clip   = clip_ff[Stages-1];
      out_data.origin = org_ff[Stages-1];
   end

endmodule

>>> design/plx_pose.sv
// Adds the origin pose and then the laser offset with saturation, and forms
// the output angle; the last stage is the response output register.
// Depends on plx_pkg.
module plx_pose import plx_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  point_type          in_data,
   input  logic signed [23:0] machine_angle,
   input  logic [63:0]        laser_offset,
   output logic               out_valid,
   input  logic               out_ready,
   output result_type         out_data
);

   localparam int Stages = 2;

   logic [Stages-1:0] vld_ff, vld_in;
   logic [Stages:0]   rdy;

   logic [32:0] sx1, sy1, sa1, sx2, sy2;
   logic signed [31:0] x1_ff, y1_ff, a1_ff, x2_ff, y2_ff, a2_ff;
   logic signed [31:0] lx, ly;
   logic clip1_ff, clip2_ff;

   always_comb begin
      rdy[Stages] = out_ready;
      for (int k = Stages - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in = (rdy[Stages-1:0] & {vld_ff[Stages-2:0], in_valid})
             | (~rdy[Stages-1:0] & vld_ff);
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[Stages-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      sx1 = sat32(64'(in_data.x) + 64'(in_data.origin.origin_x));
      sy1 = sat32(64'(in_data.y) + 64'(in_data.origin.origin_y));
      sa1 = sat32(64'(in_data.origin.origin_angle) + (64'(machine_angle) <<< 1));
      lx  = laser_offset[31:0];
      ly  = laser_offset[63:32];
      sx2 = sat32(64'(x1_ff) + 64'(lx));
      sy2 = sat32(64'(y1_ff) + 64'(ly));
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         x1_ff    <= sx1[31:0];
         y1_ff    <= sy1[31:0];
         a1_ff    <= sa1[31:0];
         clip1_ff <= in_data.clip | sx1[32] | sy1[32] | sa1[32];
      end
      if (rdy[1]) begin
         x2_ff    <= sx2[31:0];
         y2_ff    <= sy2[31:0];
         a2_ff    <= a1_ff;
         clip2_ff <= clip1_ff | sx2[32] | sy2[32];
      end
   end

   always_comb begin
      out_data.laser_x     = x2_ff;
      out_data.laser_y     = y2_ff;
      out_data.laser_angle = a2_ff;
      out_data.clipped     = clip2_ff;
   end

endmodule

>>> design/pixel_to_laser_pose_transform_unit.sv
// Top level of the pixel to laser pose transform unit: register file and the
// pipeline chain plx_distort, plx_scale, two plx_rigid and plx_pose.
// Depends on plx_pkg and the interfaces in plx_if.
//
// Usage: a request transfer carries one camera pixel (unsigned Q16.8) and an
// origin pose (Q16.16 mm and degrees). Each request produces exactly one
// response transfer with the laser pose and a flag that is set when any
// intermediate or output value saturated. Responses come out in request order.
// A request transfer loads the first of 23 register stages: ten for the
// distortion scale, five for the millimeter conversion, three for each rigid
// transform and two for the pose sums. One request is accepted every cycle
// while the pipeline is not full. When the receiver stalls, items keep
// advancing into empty stages, so requests are still accepted until all 23
// stages hold an item. The user must write registers through the csr port
// only while no items are in flight; the block itself does not enforce this.
// Synchronous reset empties the pipeline and loads the register defaults
// (unit rotations, all else zero).
module pixel_to_laser_pose_transform_unit import plx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   plx_req_if.sink     req,
   plx_rsp_if.source   rsp,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   logic [47:0] optical_center_ff;
   logic [63:0] distortion_coeffs_ff;
   logic [63:0] pixel_pitch_ff;
   logic [39:0] image_rotation_ff;
   logic [63:0] image_translation_ff;
   logic [63:0] machine_rotation_ff;
   logic [63:0] machine_translation_ff;
   logic [63:0] laser_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         optical_center_ff      <= '0;
         distortion_coeffs_ff   <= '0;
         pixel_pitch_ff         <= '0;
         image_rotation_ff      <= IMAGE_ROTATION_RESET;
         image_translation_ff   <= '0;
         machine_rotation_ff    <= MACHINE_ROTATION_RESET;
         machine_translation_ff <= '0;
         laser_offset_ff        <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_OPTICAL_CENTER:      optical_center_ff      <= csr_wdata[47:0];
            CSR_DISTORTION_COEFFS:   distortion_coeffs_ff   <= csr_wdata;
            CSR_PIXEL_PITCH:         pixel_pitch_ff         <= csr_wdata;
            CSR_IMAGE_ROTATION:      image_rotation_ff      <= csr_wdata[39:0];
            CSR_IMAGE_TRANSLATION:   image_translation_ff   <= csr_wdata;
            CSR_MACHINE_ROTATION:    machine_rotation_ff    <= csr_wdata;
            CSR_MACHINE_TRANSLATION: machine_translation_ff <= csr_wdata;
            CSR_LASER_OFFSET:        laser_offset_ff        <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   origin_type origin;
   dist_type   dist_data;
   point_type  scale_data, rigid1_data, rigid2_data;
   result_type result;
   logic dist_valid, dist_ready, scale_valid, scale_ready;
   logic rigid1_valid, rigid1_ready, rigid2_valid, rigid2_ready;

   always_comb begin
      origin.origin_x     = req.origin_x;
      origin.origin_y     = req.origin_y;
      origin.origin_angle = req.origin_angle;
   end

   plx_distort u_distort (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .pixel_x   (req.pixel_x),
      .pixel_y   (req.pixel_y),
      .origin_in (origin),
      .center_x  (optical_center_ff[23:0]),
      .center_y  (optical_center_ff[47:24]),
      .k1        (distortion_coeffs_ff[31:0]),
      .k2        (distortion_coeffs_ff[63:32]),
      .out_valid (dist_valid),
      .out_ready (dist_ready),
      .out_data  (dist_data)
   );

   plx_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dist_valid),
      .in_ready  (dist_ready),
      .in_data   (dist_data),
      .pitch_x   (pixel_pitch_ff[31:0]),
      .pitch_y   (pixel_pitch_ff[63:32]),
      .out_valid (scale_valid),
      .out_ready (scale_ready),
      .out_data  (scale_data)
   );

   plx_rigid u_rigid_image (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (scale_valid),
      .in_ready    (scale_ready),
      .in_data     (scale_data),
      .rotation    (image_rotation_ff),
      .translation (image_translation_ff),
      .out_valid   (rigid1_valid),
      .out_ready   (rigid1_ready),
      .out_data    (rigid1_data)
   );

   plx_rigid u_rigid_machine (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (rigid1_valid),
      .in_ready    (rigid1_ready),
      .in_data     (rigid1_data),
      .rotation    (machine_rotation_ff[39:0]),
      .translation (machine_translation_ff),
      .out_valid   (rigid2_valid),
      .out_ready   (rigid2_ready),
      .out_data    (rigid2_data)
   );

   plx_pose u_pose (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (rigid2_valid),
      .in_ready      (rigid2_ready),
      .in_data       (rigid2_data),
      .machine_angle (machine_rotation_ff[63:40]),
      .laser_offset  (laser_offset_ff),
      .out_valid     (rsp.valid),
      .out_ready     (rsp.ready),
      .out_data      (result)
   );

   always_comb begin
      rsp.laser_x     = result.laser_x;
      rsp.laser_y     = result.laser_y;
      rsp.laser_angle = result.laser_angle;
      rsp.clipped     = result.clipped;
   end

endmodule

>>> design/plx_checker.sv
// Port-level checker for the pixel to laser pose transform unit, with the bind
// that attaches it to the top level.
// Depends on plx_pkg.
module plx_checker import plx_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_laser_x,
   input logic signed [31:0] rsp_laser_y,
   input logic signed [31:0] rsp_laser_angle,
   input logic               rsp_clipped
);

   logic [4:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff + 5'(req_valid && req_ready) - 5'(rsp_valid && rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // A stalled response holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_laser_x)
         && $stable(rsp_laser_y) && $stable(rsp_laser_angle) && $stable(rsp_clipped))
      else $error("response changed while stalled");

   // No response appears without an outstanding request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_ff != 5'd0)
      else $error("response without outstanding request");

   // A free pipeline stage means a request can be taken.
   assert property (@(posedge clock) disable iff (reset)
      count_ff < 5'(PIPE_DEPTH) |-> req_ready)
      else $error("request refused with free pipeline stage");

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind pixel_to_laser_pose_transform_unit plx_checker u_plx_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_laser_x     (rsp.laser_x),
   .rsp_laser_y     (rsp.laser_y),
   .rsp_laser_angle (rsp.laser_angle),
   .rsp_clipped     (rsp.clipped)
);

>>> tb/pixel_to_laser_pose_transform_unit_tb.sv
// Testbench of the pixel to laser pose transform unit: directed and random pixels under
// several register settings, each response checked against an in-bench fixed point model.
// Depends on plx_pkg, the interfaces in plx_if and the unit itself.
module pixel_to_laser_pose_transform_unit_tb;
   import plx_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam longint WORD_MAX = 64'sh7fffffffffffffff;

   typedef struct {
      logic [23:0]        pixel_x;
      logic [23:0]        pixel_y;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_angle;
   } pixel_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   plx_req_if req_if();
   plx_rsp_if rsp_if();

   pixel_to_laser_pose_transform_unit uut (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   logic [63:0] reg_shadow [8];
   result_type  pose_queue [$];
   bit          steady = 1'b0;
   int          mismatches = 0;
   int          responses = 0;
   int          requests = 0;
   int          settings = 0;
   int          cycles = 0;

   always #1 clock = ~clock;

   initial begin
      req_if.valid = 1'b0;
      req_if.pixel_x = '0;
      req_if.pixel_y = '0;
      req_if.origin_x = '0;
      req_if.origin_y = '0;
      req_if.origin_angle = '0;
      rsp_if.ready = 1'b0;
   end

   function automatic bit idle_now();
      return !steady && $urandom_range(99) < 32;
   endfunction

   always @(negedge clock) begin
      rsp_if.ready <= !idle_now();
   end

   function automatic longint mul_round(longint a, longint b, int sh, inout bit clip);
      logic signed [127:0] sa, sb;
      logic [127:0] prod;
      bit neg;
      sa = a;
      sb = b;
      neg = (a < 0) != (b < 0);
      prod = (sa < 0 ? -sa : sa) * (sb < 0 ? -sb : sb);
      prod = (prod + (128'd1 << (sh - 1))) >> sh;
      if (prod > 128'(WORD_MAX)) begin
         clip = 1'b1;
         return neg ? -WORD_MAX : WORD_MAX;
      end
      return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
   endfunction

   function automatic longint sat_word(longint v, inout bit clip);
      if (v > 64'sd2147483647) begin
         clip = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         clip = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic void apply_rigid(inout longint x, inout longint y,
                                       input logic [63:0] rot, input logic [63:0] shift,
                                       inout bit clip);
      longint c, s, rx, ry;
      c = longint'($signed(rot[19:0]));
      s = longint'($signed(rot[39:20]));
      rx = (x * c - y * s + 64'sd131072) >>> 18;
      ry = (x * s + y * c + 64'sd131072) >>> 18;
      x = sat_word(rx + longint'($signed(shift[31:0])), clip);
      y = sat_word(ry + longint'($signed(shift[63:32])), clip);
   endfunction

   function automatic result_type predict_pose(pixel_item_type it);
      result_type r;
      bit clip;
      longint dx, dy, r2, k1, k2, inner, scale, ux, uy, x, y, ang;
      clip = 1'b0;
      dx = longint'(it.pixel_x) - longint'(reg_shadow[CSR_OPTICAL_CENTER][23:0]);
      dy = longint'(it.pixel_y) - longint'(reg_shadow[CSR_OPTICAL_CENTER][47:24]);
      r2 = dx * dx + dy * dy;
      k1 = longint'($signed(reg_shadow[CSR_DISTORTION_COEFFS][31:0]));
      k2 = longint'($signed(reg_shadow[CSR_DISTORTION_COEFFS][63:32]));
      inner = k1 * 256 + mul_round(k2, r2, 48, clip);
      scale = (64'sd1 <<< 32) + mul_round(inner, r2, 48, clip);
      ux = mul_round(dx, scale, 32, clip);
      uy = mul_round(dy, scale, 32, clip);
      x = sat_word(mul_round(ux, longint'(reg_shadow[CSR_PIXEL_PITCH][31:0]), 20, clip), clip);
      y = sat_word(mul_round(uy, longint'(reg_shadow[CSR_PIXEL_PITCH][63:32]), 20, clip), clip);
      apply_rigid(x, y, reg_shadow[CSR_IMAGE_ROTATION], reg_shadow[CSR_IMAGE_TRANSLATION], clip);
      apply_rigid(x, y, reg_shadow[CSR_MACHINE_ROTATION], reg_shadow[CSR_MACHINE_TRANSLATION],
                  clip);
      x = sat_word(x + longint'(it.origin_x), clip);
      y = sat_word(y + longint'(it.origin_y), clip);
      x = sat_word(x + longint'($signed(reg_shadow[CSR_LASER_OFFSET][31:0])), clip);
      y = sat_word(y + longint'($signed(reg_shadow[CSR_LASER_OFFSET][63:32])), clip);
      ang = sat_word(longint'(it.origin_angle)
                     + 2 * longint'($signed(reg_shadow[CSR_MACHINE_ROTATION][63:40])), clip);
      r.laser_x = x[31:0];
      r.laser_y = y[31:0];
      r.laser_angle = ang[31:0];
      r.clipped = clip;
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else if (!reset && rsp_if.valid && rsp_if.ready) begin
         responses <= responses + 1;
         if (pose_queue.size() == 0) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("Response transfer with nothing outstanding.");
         end else begin
            want = pose_queue.pop_front();
            if (rsp_if.laser_x !== want.laser_x || rsp_if.laser_y !== want.laser_y ||
                rsp_if.laser_angle !== want.laser_angle || rsp_if.clipped !== want.clipped) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("Mismatch: expected x %h y %h angle %h clip %b, got %h %h %h %b",
                           want.laser_x, want.laser_y, want.laser_angle, want.clipped,
                           rsp_if.laser_x, rsp_if.laser_y, rsp_if.laser_angle, rsp_if.clipped);
            end
         end
      end
   end

   task automatic send_pixel(pixel_item_type it);
      while (idle_now()) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.pixel_x <= it.pixel_x;
      req_if.pixel_y <= it.pixel_y;
      req_if.origin_x <= it.origin_x;
      req_if.origin_y <= it.origin_y;
      req_if.origin_angle <= it.origin_angle;
      do @(posedge clock); while (!req_if.ready);
      pose_queue.push_back(predict_pose(it));
      requests++;
   endtask

   task automatic drain_poses();
      @(negedge clock);
      req_if.valid <= 1'b0;
      wait (pose_queue.size() == 0);
      repeat (PIPE_DEPTH + 5) @(posedge clock);
   endtask

   task automatic load_registers(logic [63:0] vals [8]);
      drain_poses();
      for (int i = 0; i < 8; i++) begin
         @(negedge clock);
         csr_wr_en <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         reg_shadow[i] = vals[i];
      end
      reg_shadow[CSR_OPTICAL_CENTER][63:48] = '0;
      reg_shadow[CSR_IMAGE_ROTATION][63:40] = '0;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      settings++;
   endtask

   function automatic pixel_item_type random_pixel(bit wide);
      pixel_item_type it;
      it.pixel_x = wide ? 24'($urandom) : 24'($urandom_range(0, 1 << 20));
      it.pixel_y = wide ? 24'($urandom) : 24'($urandom_range(0, 1 << 20));
      it.origin_x = wide ? $urandom : $signed(32'($urandom_range(0, 1 << 26))) - (1 << 25);
      it.origin_y = wide ? $urandom : $signed(32'($urandom_range(0, 1 << 26))) - (1 << 25);
      it.origin_angle = wide ? $urandom : $signed(32'($urandom_range(0, 1 << 25))) - (1 << 24);
      return it;
   endfunction

   function automatic logic [39:0] rotation_word(real deg);
      logic [19:0] c, s;
      c = 20'($rtoi($cos(deg * 3.14159265358979 / 180.0) * 262144.0));
      s = 20'($rtoi($sin(deg * 3.14159265358979 / 180.0) * 262144.0));
      return {s, c};
   endfunction

   function automatic logic [63:0] signed_pair(int span);
      logic [31:0] a, b;
      a = 32'($urandom_range(0, 2 * span)) - 32'(span);
      b = 32'($urandom_range(0, 2 * span)) - 32'(span);
      return {b, a};
   endfunction

   task automatic plausible_setting();
      logic [63:0] v [8];
      int mdeg;
      mdeg = $urandom_range(0, 719) - 360;
      v[CSR_OPTICAL_CENTER] = {24'($urandom_range(0, 1 << 20)), 24'($urandom_range(0, 1 << 20))};
      v[CSR_DISTORTION_COEFFS] = {32'($urandom_range(0, 1 << 14)) - 32'(1 << 13),
                                  32'($urandom_range(0, 1 << 18)) - 32'(1 << 17)};
      v[CSR_PIXEL_PITCH] = {32'($urandom_range(1 << 20, 1 << 23)),
                            32'($urandom_range(1 << 20, 1 << 23))};
      v[CSR_IMAGE_ROTATION] = {24'd0, rotation_word($urandom_range(0, 359))};
      v[CSR_IMAGE_TRANSLATION] = signed_pair(1 << 24);
      v[CSR_MACHINE_ROTATION] = {24'(mdeg * 32768), rotation_word(mdeg)};
      v[CSR_MACHINE_TRANSLATION] = signed_pair(1 << 24);
      v[CSR_LASER_OFFSET] = signed_pair(1 << 22);
      load_registers(v);
   endtask

   task automatic wild_setting();
      logic [63:0] v [8];
      for (int i = 0; i < 8; i++) v[i] = {$urandom, $urandom};
      load_registers(v);
   endtask

   task automatic test_reset_defaults();
      pixel_item_type it;
      it = '{24'h0, 24'h0, 32'sh0, 32'sh0, 32'sh0};
      send_pixel(it);
      it = '{24'hffffff, 24'hffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
      send_pixel(it);
      it = '{24'hffffff, 24'h0, -32'sh80000000, -32'sh80000000, -32'sh80000000};
      send_pixel(it);
      it = '{24'h000100, 24'h012345, 32'sh00010000, -32'sh00010000, 32'sh005a0000};
      send_pixel(it);
      for (int i = 0; i < 4; i++) send_pixel(random_pixel(1'b1));
   endtask

   task automatic test_extreme_settings();
      logic [63:0] v [8];
      pixel_item_type it;
      for (int i = 0; i < 8; i++) v[i] = '1;
      load_registers(v);
      it = '{24'h0, 24'h0, 32'sh0, 32'sh0, 32'sh0};
      send_pixel(it);
      it = '{24'hffffff, 24'hffffff, 32'sh7fffffff, -32'sh80000000, 32'sh7fffffff};
      send_pixel(it);
      for (int i = 0; i < 3; i++) send_pixel(random_pixel(1'b1));
      v[CSR_OPTICAL_CENTER] = '0;
      v[CSR_DISTORTION_COEFFS] = {32'h7fffffff, 32'h7fffffff};
      v[CSR_PIXEL_PITCH] = {32'hffffffff, 32'hffffffff};
      v[CSR_IMAGE_ROTATION] = {20'h80000, 20'h7ffff};
      v[CSR_IMAGE_TRANSLATION] = {32'h7fffffff, 32'h80000000};
      v[CSR_MACHINE_ROTATION] = {24'h7fffff, 20'h80000, 20'h80000};
      v[CSR_MACHINE_TRANSLATION] = {32'h80000000, 32'h7fffffff};
      v[CSR_LASER_OFFSET] = {32'h80000000, 32'h80000000};
      load_registers(v);
      it = '{24'hffffff, 24'h000001, -32'sh80000000, 32'sh7fffffff, -32'sh80000000};
      send_pixel(it);
      it = '{24'h000001, 24'hffffff, 32'sh0, 32'sh0, 32'sh0};
      send_pixel(it);
      for (int i = 0; i < 3; i++) send_pixel(random_pixel(1'b1));
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 7; phase++) begin
         if (phase % 3 == 2) wild_setting();
         else plausible_setting();
         steady = (phase == 1);
         for (int i = 0; i < 130; i++) begin
            send_pixel(random_pixel($urandom_range(99) < 25));
            if (i == 60) drain_poses();
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < 8; i++) reg_shadow[i] = '0;
      reg_shadow[CSR_IMAGE_ROTATION] = 64'(IMAGE_ROTATION_RESET);
      reg_shadow[CSR_MACHINE_ROTATION] = MACHINE_ROTATION_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_extreme_settings();
      test_random_settings();
      drain_poses();
      $display("Sent %0d pixels and checked %0d poses across %0d register settings.",
               requests, responses, settings);
      $display("Settings spanned reset defaults, all-ones, saturating and plausible optics.");
      if (mismatches == 0 && pose_queue.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
